// ===== rtl/sge_pkg.sv =====
// Package for the spin glass energy census block.
// Holds field widths, register indexes, item modes and the accumulator command type.
// No dependencies.
package sge_pkg;

    localparam int COUPLING_W  = 16;
    localparam int ENERGY_W    = 32;
    localparam int COUNT_W     = 17;
    localparam int SPIN_IDX_W  = 4;
    localparam int COUP_ADDR_W = 2 * SPIN_IDX_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int SPIN_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SPIN_COUNT       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 1'd1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RUN   = 1'b1;

    typedef enum logic [2:0] {
        ACC_NOP,
        ACC_CLEAR,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD2,
        ACC_SUB2
    } acc_op_t;

    typedef struct packed {
        acc_op_t                     op;
        logic signed [ENERGY_W-1:0]  operand;
    } acc_cmd_t;

endpackage

// ===== rtl/sge_req_if.sv =====
// Input channel of the spin glass energy census block: coupling writes and run requests.
// Depends on sge_pkg.
interface sge_req_if
    import sge_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [SPIN_IDX_W-1:0]         row_spin;
    logic [SPIN_IDX_W-1:0]         col_spin;
    logic signed [COUPLING_W-1:0]  coupling;

    modport source (output valid, mode, row_spin, col_spin, coupling, input ready);
    modport sink   (input valid, mode, row_spin, col_spin, coupling, output ready);
endinterface

// ===== rtl/sge_rsp_if.sv =====
// Output channel of the spin glass energy census block: one match count per run.
// Depends on sge_pkg.
interface sge_rsp_if
    import sge_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, match_count, input ready);
    modport sink   (input valid, match_count, output ready);
endinterface

// ===== rtl/sge_accum.sv =====
// Shared energy accumulator: clear, load, add a coupling or add/subtract twice a coupling.
// Depends on sge_pkg.
module sge_accum
    import sge_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  acc_cmd_t                    cmd,
    output logic signed [ENERGY_W-1:0]  acc
);

    logic signed [ENERGY_W-1:0] acc_reg;
    logic signed [ENERGY_W-1:0] acc_next;
    logic signed [ENERGY_W-1:0] twice;

    assign twice = cmd.operand <<< 1;

    always_comb
    begin
        unique case (cmd.op)
            ACC_CLEAR: acc_next = '0;
            ACC_LOAD:  acc_next = cmd.operand;
            ACC_ADD:   acc_next = acc_reg + cmd.operand;
            ACC_ADD2:  acc_next = acc_reg + twice;
            ACC_SUB2:  acc_next = acc_reg - twice;
            default:   acc_next = acc_reg;
        endcase
    end

    // Clear on reset; every run also starts with a clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/spin_glass_energy_threshold_count.sv =====
// Exhaustive energy census of an n-spin Ising glass. Coupling writes (mode 0) are taken
// while idle. A run (mode 1) sums the couplings once, then visits every spin mask, each
// mask's energy built from its predecessor's stored energy plus one term per other spin.
// One adder and the single read port of the coupling store set the pace. The input is
// not ready during a run; a finished count may wait in the output register while the
// next items are taken.
module spin_glass_energy_threshold_count
    import sge_pkg::*;
#(
    parameter int MAX_SPINS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    sge_req_if.sink                req,
    sge_rsp_if.source              rsp
);

    localparam int SPIN_W = $clog2(MAX_SPINS);
    localparam int CNT_W  = $clog2(MAX_SPINS + 1);
    localparam int DEPTH  = 1 << MAX_SPINS;
    localparam int COUP_DEPTH = 1 << COUP_ADDR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_TERM  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [SPIN_CNT_W-1:0]        spin_count_reg;
    logic signed [ENERGY_W-1:0]   threshold_reg;

    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [CNT_W-1:0]             i_reg, i_next;
    logic [CNT_W-1:0]             j_reg, j_next;
    logic [SPIN_W-1:0]            b_reg, b_next;
    logic [MAX_SPINS-1:0]         mask_reg, mask_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    acc_op_t                      op_reg, op_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [COUNT_W-1:0]           rsp_count_reg, rsp_count_next;

    logic signed [COUPLING_W-1:0] coup_store [COUP_DEPTH];
    logic signed [COUPLING_W-1:0] coup_rdata_reg;
    logic [COUP_ADDR_W-1:0]       coup_raddr;
    logic                         coup_we;

    logic signed [ENERGY_W-1:0]   energy_table [DEPTH];
    logic signed [ENERGY_W-1:0]   energy_rdata_reg;
    logic [MAX_SPINS-1:0]         energy_raddr;
    logic                         energy_we;

    logic [SPIN_W-1:0]            low_bit;
    logic [MAX_SPINS-1:0]         last_mask;
    logic [SPIN_CNT_W-1:0]        n_eff;
    logic                         in_xfer;
    logic                         rsp_free;
    logic                         pair_done;
    logic signed [ENERGY_W-1:0]   acc;
    acc_cmd_t                     acc_cmd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_count_reg <= SPIN_CNT_W'(16);
            threshold_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SPIN_COUNT:       spin_count_reg <= cfg_wdata[SPIN_CNT_W-1:0];
                REG_ENERGY_THRESHOLD: threshold_reg  <= $signed(cfg_wdata[ENERGY_W-1:0]);
                default:              ;
            endcase
        end
    end

    assign in_xfer  = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign n_eff    = (spin_count_reg > SPIN_CNT_W'(MAX_SPINS)) ? SPIN_CNT_W'(MAX_SPINS)
                                                               : spin_count_reg;
    assign last_mask = ~({MAX_SPINS{1'b1}} << n_reg);
    assign pair_done = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(2)) >= (CNT_W+1)'(n_reg);

    // Lowest set bit of the current mask
    always_comb
    begin
        low_bit = '0;
        for (int k = MAX_SPINS - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                low_bit = SPIN_W'(k);
            end
        end
    end

    // Coupling store: written on a write transfer with row below column, read every cycle
    assign coup_we = in_xfer && (req.mode == MODE_WRITE) && (req.row_spin < req.col_spin)
                     && (int'(req.col_spin) < MAX_SPINS);

    always_comb
    begin
        if (state_reg == S_TERM && j_reg < CNT_W'(b_reg))
        begin
            coup_raddr = {SPIN_IDX_W'(j_reg), SPIN_IDX_W'(b_reg)};
        end
        else if (state_reg == S_TERM)
        begin
            coup_raddr = {SPIN_IDX_W'(b_reg), SPIN_IDX_W'(j_reg)};
        end
        else
        begin
            coup_raddr = {SPIN_IDX_W'(i_reg), SPIN_IDX_W'(j_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (coup_we)
        begin
            coup_store[{req.row_spin, req.col_spin}] <= req.coupling;
        end
        coup_rdata_reg <= coup_store[coup_raddr];
    end

    // Energy table: predecessor mask has its lowest set bit cleared
    assign energy_raddr = mask_reg & (mask_reg - MAX_SPINS'(1));
    assign energy_we    = (state_reg == S_EVAL);

    always_ff @(posedge clk)
    begin
        if (energy_we)
        begin
            energy_table[mask_reg] <= acc;
        end
        energy_rdata_reg <= energy_table[energy_raddr];
    end

    // Memory read data is registered and lines up with the registered op that issued it
    always_comb
    begin
        acc_cmd.op = op_reg;
        if (op_reg == ACC_LOAD)
        begin
            acc_cmd.operand = energy_rdata_reg;
        end
        else
        begin
            acc_cmd.operand = ENERGY_W'(coup_rdata_reg);
        end
    end

    sge_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acc_cmd),
        .acc   (acc)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        b_next         = b_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        op_next        = ACC_NOP;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_count_next = rsp_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && req.mode == MODE_RUN)
                begin
                    n_next     = CNT_W'(n_eff);
                    i_next     = '0;
                    j_next     = CNT_W'(1);
                    mask_next  = '0;
                    count_next = '0;
                    op_next    = ACC_CLEAR;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (j_reg < n_reg)
                begin
                    op_next = ACC_ADD;
                    j_next  = j_reg + CNT_W'(1);
                end
                else if (pair_done)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                    j_next = i_reg + CNT_W'(2);
                end
            end
            S_DRAIN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (acc <= threshold_reg && count_reg != {COUNT_W{1'b1}})
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                if (mask_reg == last_mask)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mask_next  = mask_reg + MAX_SPINS'(1);
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                b_next     = low_bit;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                op_next    = ACC_LOAD;
                j_next     = '0;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (j_reg < n_reg)
                begin
                    if (j_reg != CNT_W'(b_reg))
                    begin
                        op_next = mask_reg[j_reg[SPIN_W-1:0]] ? ACC_ADD2 : ACC_SUB2;
                    end
                    j_next = j_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= ACC_NOP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        b_reg         <= b_next;
        mask_reg      <= mask_next;
        count_reg     <= count_next;
        rsp_count_reg <= rsp_count_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.match_count = rsp_count_reg;

endmodule
